// ===== sv/glos_pkg.sv =====
// grid line-of-sight check: shared types and constants
// used by the interfaces, the controller, the datapath and the top level
package glos_pkg;

  localparam int unsigned MAP_BITS   = 6;
  localparam int unsigned ADDR_BITS  = 2 * MAP_BITS;
  localparam int unsigned DOOR_BITS  = 7;
  localparam int unsigned POS_W      = 22;
  localparam int unsigned FRAC       = 8;
  localparam int unsigned P_W        = POS_W - FRAC;
  localparam int unsigned NUM_W      = P_W + FRAC;
  localparam int unsigned SLOPE_W    = 16;
  localparam int unsigned ACC_W      = 25;
  localparam int unsigned DIVC_W     = 5;
  localparam logic [DIVC_W-1:0] DIV_STEPS = DIVC_W'(NUM_W);
  localparam logic [SLOPE_W-2:0] SLOPE_LIMIT = 15'h7fff;
  localparam logic [FRAC:0] FRAC_ONE = 9'd256;

  localparam logic [1:0] KIND_CELL  = 2'd0;
  localparam logic [1:0] KIND_DOOR  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef struct packed {
    logic clr_step;
    logic wr_cell;
    logic wr_door;
    logic q_load;
    logic setup;
    logic div_step;
    logic slope_ld;
    logic init;
    logic step;
    logic pass_next;
  } glos_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic dist_zero;
    logic div_done;
    logic steps_done;
    logic cell_zero;
    logic cell_wall;
    logic door_block;
    logic pass_last;
  } glos_sts_t;

endpackage

// ===== sv/glos_if.sv =====
// grid line-of-sight check: request and result channel interfaces
// depends on glos_pkg
interface glos_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [glos_pkg::MAP_BITS-1:0]  cell_x;
  logic [glos_pkg::MAP_BITS-1:0]  cell_y;
  logic [7:0]                     cell_value;
  logic [glos_pkg::DOOR_BITS-1:0] door_index;
  logic [15:0]                    door_position;
  logic [glos_pkg::POS_W-1:0]     from_x;
  logic [glos_pkg::POS_W-1:0]     from_y;
  logic [glos_pkg::POS_W-1:0]     to_x;
  logic [glos_pkg::POS_W-1:0]     to_y;
  logic [glos_pkg::MAP_BITS-1:0]  target_tile_x;
  logic [glos_pkg::MAP_BITS-1:0]  target_tile_y;

  modport source (output valid, kind, cell_x, cell_y, cell_value, door_index,
                  door_position, from_x, from_y, to_x, to_y, target_tile_x,
                  target_tile_y, input ready);
  modport sink (input valid, kind, cell_x, cell_y, cell_value, door_index,
                door_position, from_x, from_y, to_x, to_y, target_tile_x,
                target_tile_y, output ready);
endinterface

interface glos_res_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

// ===== sv/glos_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module glos_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/glos_datapath.sv =====
// grid line-of-sight check datapath: stores, slope divider, accumulator
// depends on glos_pkg and glos_ram
module glos_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  glos_pkg::glos_cmd_t            cmd_i,
  output glos_pkg::glos_sts_t            sts_o,
  input  logic [glos_pkg::MAP_BITS-1:0]  cell_x_i,
  input  logic [glos_pkg::MAP_BITS-1:0]  cell_y_i,
  input  logic [7:0]                     cell_value_i,
  input  logic [glos_pkg::DOOR_BITS-1:0] door_index_i,
  input  logic [15:0]                    door_position_i,
  input  logic [glos_pkg::POS_W-1:0]     from_x_i,
  input  logic [glos_pkg::POS_W-1:0]     from_y_i,
  input  logic [glos_pkg::POS_W-1:0]     to_x_i,
  input  logic [glos_pkg::POS_W-1:0]     to_y_i,
  input  logic [glos_pkg::MAP_BITS-1:0]  target_tile_x_i,
  input  logic [glos_pkg::MAP_BITS-1:0]  target_tile_y_i
);
  import glos_pkg::*;

  logic [P_W-1:0]      fx_q, fy_q, tx_q, ty_q, b1_q, span_q;
  logic [MAP_BITS-1:0] ttx_q, tty_q, cnt_q, major_q;
  logic                pass_q, up_q, neg_q;
  logic [FRAC:0]       partial_q;
  logic [NUM_W-1:0]    num_q;
  logic [P_W:0]        rem_q;
  logic [DIVC_W-1:0]   divc_q;
  logic signed [SLOPE_W-1:0] slope_q;
  logic signed [ACC_W-1:0]   acc_q, icpt_q;
  logic [ADDR_BITS-1:0]      clr_q;

  logic [P_W-1:0]      a1, b1, a2, b2, sp, nd_mag;
  logic [MAP_BITS-1:0] ta1, ta2, dist_abs, minor;
  logic [MAP_BITS:0]   tile_dist;
  logic                dist_up;
  logic [FRAC:0]       part;
  logic [P_W:0]        trial;
  logic                ge;
  logic [SLOPE_W-2:0]  smag;
  logic signed [SLOPE_W-1:0] slope_c, half;
  logic signed [ACC_W+1-1:0] prod_c;
  logic signed [ACC_W-1:0]   prod_sh, slope_x, half_x, acc_nx;

  logic                 tile_we, door_we;
  logic [ADDR_BITS-1:0] tile_waddr, tile_raddr;
  logic [7:0]           tile_wdata, tile_rdata;
  logic [DOOR_BITS-1:0] door_waddr;
  logic [15:0]          door_wdata, door_rdata;

  assign a1  = pass_q ? fy_q : fx_q;
  assign b1  = pass_q ? fx_q : fy_q;
  assign a2  = pass_q ? ty_q : tx_q;
  assign b2  = pass_q ? tx_q : ty_q;
  assign ta1 = a1[P_W-1 -: MAP_BITS];
  assign ta2 = pass_q ? tty_q : ttx_q;
  assign tile_dist = {1'b0, ta2} - {1'b0, ta1};
  assign dist_up   = !tile_dist[MAP_BITS] && (tile_dist != '0);
  assign dist_abs  = tile_dist[MAP_BITS] ? MAP_BITS'(-tile_dist) : tile_dist[MAP_BITS-1:0];
  assign part     = dist_up ? FRAC_ONE - {1'b0, a1[FRAC-1:0]} : {1'b0, a1[FRAC-1:0]};
  assign sp       = (a2 >= a1) ? a2 - a1 : a1 - a2;
  assign nd_mag   = (b2 >= b1) ? b2 - b1 : b1 - b2;

  assign trial = {rem_q[P_W-1:0], num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, span_q};

  assign smag    = (num_q[NUM_W-1:SLOPE_W-1] != '0) ? SLOPE_LIMIT : num_q[SLOPE_W-2:0];
  assign slope_c = neg_q ? -$signed({1'b0, smag}) : $signed({1'b0, smag});

  assign prod_c  = slope_q * $signed({1'b0, partial_q});
  assign prod_sh = ACC_W'(prod_c >>> FRAC);
  assign half    = (slope_q + $signed({{(SLOPE_W-1){1'b0}}, slope_q[SLOPE_W-1]})) >>> 1;
  assign slope_x = ACC_W'(slope_q);
  assign half_x  = ACC_W'(half);
  assign acc_nx  = acc_q + slope_x;

  assign minor      = acc_q[FRAC +: MAP_BITS];
  assign tile_raddr = pass_q ? {minor, major_q} : {major_q, minor};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      pass_q <= 1'b0;
      divc_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.q_load) begin
        pass_q <= 1'b0;
      end else if (cmd_i.pass_next) begin
        pass_q <= 1'b1;
      end
      if (cmd_i.setup) begin
        divc_q <= DIV_STEPS;
        cnt_q  <= dist_abs;
      end else begin
        if (cmd_i.div_step) begin
          divc_q <= divc_q - 1'b1;
        end
        if (cmd_i.step) begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load) begin
      fx_q  <= from_x_i[POS_W-1:FRAC];
      fy_q  <= from_y_i[POS_W-1:FRAC];
      tx_q  <= to_x_i[POS_W-1:FRAC];
      ty_q  <= to_y_i[POS_W-1:FRAC];
      ttx_q <= target_tile_x_i;
      tty_q <= target_tile_y_i;
    end
    if (cmd_i.setup) begin
      up_q      <= dist_up;
      partial_q <= part;
      span_q    <= (sp == '0) ? P_W'(1) : sp;
      neg_q     <= b2 < b1;
      num_q     <= {nd_mag, {FRAC{1'b0}}};
      rem_q     <= '0;
      b1_q      <= b1;
      major_q   <= dist_up ? ta1 + 1'b1 : ta1 - 1'b1;
    end
    if (cmd_i.div_step) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? trial - {1'b0, span_q} : trial;
    end
    if (cmd_i.slope_ld) begin
      slope_q <= slope_c;
    end
    if (cmd_i.init) begin
      acc_q <= $signed({{(ACC_W-P_W){1'b0}}, b1_q}) + prod_sh;
    end
    if (cmd_i.step) begin
      acc_q   <= acc_nx;
      icpt_q  <= acc_nx - half_x;
      major_q <= up_q ? major_q + 1'b1 : major_q - 1'b1;
    end
  end

  assign tile_we    = cmd_i.clr_step || cmd_i.wr_cell;
  assign tile_waddr = cmd_i.clr_step ? clr_q : {cell_x_i, cell_y_i};
  assign tile_wdata = cmd_i.clr_step ? 8'd0 : cell_value_i;
  assign door_we    = cmd_i.clr_step || cmd_i.wr_door;
  assign door_waddr = cmd_i.clr_step ? clr_q[DOOR_BITS-1:0] : door_index_i;
  assign door_wdata = cmd_i.clr_step ? 16'd0 : door_position_i;

  glos_ram #(.WIDTH(8), .DEPTH(1 << ADDR_BITS)) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (tile_we),
    .waddr_i (tile_waddr),
    .wdata_i (tile_wdata),
    .raddr_i (tile_raddr),
    .rdata_o (tile_rdata)
  );

  glos_ram #(.WIDTH(16), .DEPTH(1 << DOOR_BITS)) u_door_ram (
    .clk_i   (clk_i),
    .we_i    (door_we),
    .waddr_i (door_waddr),
    .wdata_i (door_wdata),
    .raddr_i (tile_rdata[DOOR_BITS-1:0]),
    .rdata_o (door_rdata)
  );

  always_comb begin
    sts_o.clr_done   = &clr_q;
    sts_o.dist_zero  = tile_dist == '0;
    sts_o.div_done   = divc_q == '0;
    sts_o.steps_done = cnt_q == '0;
    sts_o.cell_zero  = tile_rdata == 8'd0;
    sts_o.cell_wall  = !tile_rdata[7] && (tile_rdata != 8'd0);
    sts_o.door_block = icpt_q[ACC_W-1] ||
                       (icpt_q[ACC_W-2:0] > {{(ACC_W-17){1'b0}}, door_rdata});
    sts_o.pass_last  = pass_q;
  end

endmodule

// ===== sv/glos_ctrl.sv =====
// grid line-of-sight check controller: clear sweep, query sequencing, result register
// depends on glos_pkg
module glos_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_kind_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                visible_o,
  output glos_pkg::glos_cmd_t cmd_o,
  input  glos_pkg::glos_sts_t sts_i
);
  import glos_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_SETUP = 10'b0000000100,
    S_DIV   = 10'b0000001000,
    S_SLOPE = 10'b0000010000,
    S_INIT  = 10'b0000100000,
    S_STEP  = 10'b0001000000,
    S_CELL  = 10'b0010000000,
    S_DOOR  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } glos_state_e;

  glos_state_e state_q, state_d;
  logic        res_q, res_d;
  logic        out_valid_q, out_valid_d;
  logic        visible_q, visible_d;
  logic        accept;

  assign in_ready_o  = state_q == S_IDLE;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    visible_d   = visible_q;
    cmd_o       = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.wr_cell = in_kind_i == KIND_CELL;
          cmd_o.wr_door = in_kind_i == KIND_DOOR;
          if (in_kind_i == KIND_QUERY) begin
            cmd_o.q_load = 1'b1;
            state_d      = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        if (!sts_i.dist_zero) begin
          state_d = S_DIV;
        end else if (sts_i.pass_last) begin
          res_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.pass_next = 1'b1;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_SLOPE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_SLOPE: begin
        cmd_o.slope_ld = 1'b1;
        state_d        = S_INIT;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_STEP;
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = S_CELL;
      end
      S_CELL, S_DOOR: begin
        if ((state_q == S_CELL && sts_i.cell_wall) ||
            (state_q == S_DOOR && sts_i.door_block)) begin
          res_d   = 1'b0;
          state_d = S_DONE;
        end else if (state_q == S_CELL && !sts_i.cell_zero) begin
          state_d = S_DOOR;
        end else if (!sts_i.steps_done) begin
          state_d = S_STEP;
        end else if (sts_i.pass_last) begin
          res_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.pass_next = 1'b1;
          state_d         = S_SETUP;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          visible_d   = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    visible_q <= visible_d;
  end

`ifndef SYNTHESIS
  a_query_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_kind_i == KIND_QUERY) |=> !in_ready_o)
    else $error("input taken while a query is running");
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");
  a_step_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> !sts_i.steps_done)
    else $error("grid step with no tiles left");
`endif

endmodule

// ===== sv/grid_line_of_sight_check.sv =====
// grid line-of-sight check top level
// depends on glos_pkg, glos_if, glos_ctrl, glos_datapath, glos_ram
//
// usage: words arrive on in_i (valid/ready). a cell write or door write is
// stored on acceptance and gives no result. a query runs two grid passes,
// one over columns and one over rows, and returns one word on out_o with
// the visible bit. a pass with no tile to cross ends at setup; otherwise it
// runs setup, the serial slope divider and, per tile crossed, a tile read,
// plus a door table read when the tile holds a door. the tile memory has a
// single read port.
// after reset the block clears the tile map and door table, one entry per
// cycle, and takes no word until that is done.
// the result sits in an output register: a new word is taken while it
// waits, but a finished query holds until the receiver has taken the
// previous result.
module grid_line_of_sight_check (
  input logic      clk_i,
  input logic      rst_ni,
  glos_req_if.sink in_i,
  glos_res_if.source out_o
);
  import glos_pkg::*;

  glos_cmd_t cmd;
  glos_sts_t sts;

  glos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .visible_o   (out_o.visible),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  glos_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cell_x_i        (in_i.cell_x),
    .cell_y_i        (in_i.cell_y),
    .cell_value_i    (in_i.cell_value),
    .door_index_i    (in_i.door_index),
    .door_position_i (in_i.door_position),
    .from_x_i        (in_i.from_x),
    .from_y_i        (in_i.from_y),
    .to_x_i          (in_i.to_x),
    .to_y_i          (in_i.to_y),
    .target_tile_x_i (in_i.target_tile_x),
    .target_tile_y_i (in_i.target_tile_y)
  );

endmodule

// ===== verif/tb.sv =====
// testbench for grid_line_of_sight_check: random and directed request words,
// an in-bench model of the tile map, door table and two grid passes, and a result scoreboard
// depends on glos_pkg, glos_if and the block rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import glos_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  cx, cy;
    logic [7:0]  cval;
    logic [6:0]  didx;
    logic [15:0] dpos;
    logic [21:0] fx, fy, tx, ty;
    logic [5:0]  ttx, tty;
    bit          drain;
  } req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  glos_req_if in_if();
  glos_res_if out_if();

  grid_line_of_sight_check u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  logic [7:0]  tile_mem[4096];
  logic [15:0] door_mem[128];
  req_t        pend_q[$];
  bit          visible_due[$];
  int          mismatches = 0;
  int          got_cnt = 0;
  int          query_cnt = 0;
  int          blocked_cnt = 0;
  bit          req_taken = 0;
  int          gap_cnt = 0;
  int          sent_cnt = 0;
  int          hold_cnt = 0;
  bit          did_hold = 0;
  int          idle_cycles = 0;

  function automatic int wrap_idx(int v);
    int r;
    r = v % 64;
    if (r < 0) r += 64;
    return r;
  endfunction

  function automatic bit pass_clear(int a1, int b1, int a2, int b2, int ta1, int ta2,
                                    bit along_x);
    int nsteps, dir, partial, span, slope, acc, major, minor;
    logic [7:0] tile_b;
    logic [31:0] icpt;
    nsteps = ta2 - ta1;
    if (nsteps == 0) return 1'b1;
    if (nsteps > 0) begin
      partial = 256 - (a1 & 255);
      dir = 1;
    end else begin
      partial = a1 & 255;
      dir = -1;
      nsteps = -nsteps;
    end
    span = a2 - a1;
    if (span < 0) span = -span;
    if (span == 0) span = 1;
    slope = ((b2 - b1) * 256) / span;
    if (slope > 32767) slope = 32767;
    else if (slope < -32767) slope = -32767;
    acc = b1 + ((slope * partial) >>> 8);
    major = ta1 + dir;
    for (int i = 0; i < nsteps; i++) begin
      minor = acc >>> 8;
      acc += slope;
      tile_b = along_x ? tile_mem[wrap_idx(major) * 64 + wrap_idx(minor)]
                       : tile_mem[wrap_idx(minor) * 64 + wrap_idx(major)];
      major += dir;
      if (tile_b != 8'd0) begin
        if (tile_b < 8'h80) return 1'b0;
        icpt = 32'(acc - slope / 2);
        if (icpt > {16'd0, door_mem[tile_b[6:0]]}) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit line_visible(req_t r);
    int x1, y1, x2, y2;
    x1 = int'(r.fx >> 8);
    y1 = int'(r.fy >> 8);
    x2 = int'(r.tx >> 8);
    y2 = int'(r.ty >> 8);
    return pass_clear(x1, y1, x2, y2, x1 >>> 8, int'(r.ttx), 1'b1) &&
           pass_clear(y1, x1, y2, x2, y1 >>> 8, int'(r.tty), 1'b0);
  endfunction

  function automatic req_t rand_req(logic [1:0] k);
    req_t r;
    r.kind = k;
    r.cx = 6'($urandom); r.cy = 6'($urandom); r.cval = 8'($urandom);
    r.didx = 7'($urandom); r.dpos = 16'($urandom);
    r.fx = 22'($urandom); r.fy = 22'($urandom);
    r.tx = 22'($urandom); r.ty = 22'($urandom);
    r.ttx = 6'($urandom); r.tty = 6'($urandom);
    r.drain = 0;
    return r;
  endfunction

  function automatic req_t cell_req(int x, int y, int v);
    req_t r;
    r = rand_req(KIND_CELL);
    r.cx = 6'(x); r.cy = 6'(y); r.cval = 8'(v);
    return r;
  endfunction

  function automatic req_t door_req(int i, int p);
    req_t r;
    r = rand_req(KIND_DOOR);
    r.didx = 7'(i); r.dpos = 16'(p);
    return r;
  endfunction

  function automatic req_t query_req(logic [21:0] fx, logic [21:0] fy, logic [21:0] tx,
                                     logic [21:0] ty, int ttx, int tty);
    req_t r;
    r = rand_req(KIND_QUERY);
    r.fx = fx; r.fy = fy; r.tx = tx; r.ty = ty;
    r.ttx = 6'(ttx); r.tty = 6'(tty);
    return r;
  endfunction

  function automatic int near_tile(int t);
    int v;
    v = t + $urandom_range(0, 12) - 6;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return v;
  endfunction

  function automatic req_t rand_query();
    req_t r;
    r = rand_req(KIND_QUERY);
    if ($urandom_range(0, 99) < 85) begin
      r.ttx = 6'(near_tile(int'(r.fx[21:16])));
      r.tty = 6'(near_tile(int'(r.fy[21:16])));
      if ($urandom_range(0, 99) < 80) begin
        r.tx[21:16] = r.ttx;
        r.ty[21:16] = r.tty;
      end
    end
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (!in_if.valid || req_taken) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        in_if.valid <= 1'b0;
      end else if (pend_q.size() > 0 && !(pend_q[0].drain && visible_due.size() > 0)) begin
        req_t r;
        int g;
        r = pend_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.kind <= r.kind;
        in_if.cell_x <= r.cx;
        in_if.cell_y <= r.cy;
        in_if.cell_value <= r.cval;
        in_if.door_index <= r.didx;
        in_if.door_position <= r.dpos;
        in_if.from_x <= r.fx;
        in_if.from_y <= r.fy;
        in_if.to_x <= r.tx;
        in_if.to_y <= r.ty;
        in_if.target_tile_x <= r.ttx;
        in_if.target_tile_y <= r.tty;
        sent_cnt <= sent_cnt + 1;
        g = $urandom_range(0, 99);
        if ((sent_cnt % 400) < 80) gap_cnt <= 0;
        else if (g < 60) gap_cnt <= 0;
        else if (g < 92) gap_cnt <= $urandom_range(1, 3);
        else gap_cnt <= $urandom_range(10, 60);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (!did_hold && got_cnt >= 150) begin
      did_hold <= 1;
      hold_cnt <= 1500;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 2) begin
      hold_cnt <= $urandom_range(20, 200);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ((got_cnt % 300) < 60) || ($urandom_range(0, 99) < 65);
    end
  end

  // request capture and prediction
  always @(posedge clk_i) begin
    req_taken <= in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      req_t r;
      bit vis;
      r.kind = in_if.kind;
      r.cx = in_if.cell_x; r.cy = in_if.cell_y; r.cval = in_if.cell_value;
      r.didx = in_if.door_index; r.dpos = in_if.door_position;
      r.fx = in_if.from_x; r.fy = in_if.from_y; r.tx = in_if.to_x; r.ty = in_if.to_y;
      r.ttx = in_if.target_tile_x; r.tty = in_if.target_tile_y;
      case (r.kind)
        KIND_CELL: begin
          tile_mem[{r.cx, r.cy}] = r.cval;
        end
        KIND_DOOR: begin
          door_mem[r.didx] = r.dpos;
        end
        KIND_QUERY: begin
          vis = line_visible(r);
          visible_due.push_back(vis);
          query_cnt++;
          if (!vis) blocked_cnt++;
        end
        default: ;
      endcase
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_cnt <= got_cnt + 1;
      if (visible_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word visible=%0b", out_if.visible);
      end else begin
        bit e;
        e = visible_due.pop_front();
        if (out_if.visible !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: visible expected %0b got %0b", got_cnt, e, out_if.visible);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid = 0; in_if.kind = 0; in_if.cell_x = 0; in_if.cell_y = 0;
    in_if.cell_value = 0; in_if.door_index = 0; in_if.door_position = 0;
    in_if.from_x = 0; in_if.from_y = 0; in_if.to_x = 0; in_if.to_y = 0;
    in_if.target_tile_x = 0; in_if.target_tile_y = 0;
    out_if.ready = 0;
    for (int i = 0; i < 4096; i++) tile_mem[i] = 8'd0;
    for (int i = 0; i < 128; i++) door_mem[i] = 16'd0;

    // directed: open map, same tile, extremes, walls, doors, wrap, unused kind
    pend_q.push_back(query_req(22'h0, 22'h0, 22'h0, 22'h0, 0, 0));
    pend_q.push_back(query_req(22'h3fffff, 22'h3fffff, 22'h3fffff, 22'h3fffff, 63, 63));
    pend_q.push_back(query_req(22'h0, 22'h0, 22'h3fffff, 22'h3fffff, 63, 63));
    pend_q.push_back(query_req(22'h3fffff, 22'h0, 22'h0, 22'h3fffff, 0, 63));
    pend_q.push_back(cell_req(5, 5, 1));
    pend_q.push_back(query_req(22'h28000, 22'h58000, 22'h88000, 22'h58000, 8, 5));
    pend_q.push_back(cell_req(5, 5, 8'h7f));
    pend_q.push_back(query_req(22'h58000, 22'h28000, 22'h58000, 22'h88000, 5, 8));
    pend_q.push_back(cell_req(5, 5, 8'h80));
    pend_q.push_back(query_req(22'h28000, 22'h58000, 22'h88000, 22'h58000, 8, 5));
    pend_q.push_back(door_req(0, 16'hffff));
    pend_q.push_back(query_req(22'h28000, 22'h58000, 22'h88000, 22'h58000, 8, 5));
    pend_q.push_back(query_req(22'h88000, 22'h5c000, 22'h28000, 22'h50000, 2, 5));
    pend_q.push_back(query_req(22'h28000, 22'h58000, 22'h88000, 22'h08000, 8, 0));
    pend_q.push_back(cell_req(63, 63, 8'hff));
    pend_q.push_back(door_req(127, 0));
    pend_q.push_back(query_req(22'h3e8000, 22'h3e8000, 22'h3ff000, 22'h3ff000, 63, 63));
    pend_q.push_back(cell_req(63, 0, 2));
    pend_q.push_back(query_req(22'h3f8000, 22'h0, 22'h3f8000, 22'h0, 60, 0));
    pend_q.push_back(query_req(22'h018000, 22'h018000, 22'h3f0000, 22'h018000, 63, 1));
    pend_q.push_back(rand_req(2'd3));
    pend_q.push_back(cell_req(63, 63, 0));
    pend_q.push_back(cell_req(5, 5, 0));
    pend_q.push_back(cell_req(63, 0, 0));

    for (int n = 0; n < 1950; n++) begin
      int k;
      req_t r;
      k = $urandom_range(0, 99);
      if (k < 28) begin
        r = rand_req(KIND_CELL);
        k = $urandom_range(0, 99);
        if (k < 40) r.cval = 8'd0;
        else if (k < 75) r.cval = 8'($urandom_range(128, 255));
        else r.cval = 8'($urandom_range(1, 127));
      end else if (k < 38) begin
        r = rand_req(KIND_DOOR);
      end else if (k < 96) begin
        r = rand_query();
      end else begin
        r = rand_req(2'd3);
      end
      if (n == 1000) r.drain = 1;
      pend_q.push_back(r);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i); while (pend_q.size() > 0 || in_if.valid);
    do @(posedge clk_i); while (visible_due.size() > 0);
    repeat (500) @(posedge clk_i);

    $display("%0d words sent, %0d queries checked (%0d blocked), %0d mismatches",
             sent_cnt, query_cnt, blocked_cnt, mismatches);
    if (mismatches == 0 && visible_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/glos_pkg.sv
sv/glos_if.sv
sv/glos_ram.sv
sv/glos_datapath.sv
sv/glos_ctrl.sv
sv/grid_line_of_sight_check.sv
verif/tb.sv
